[sv/csd3_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the 3D smooth-damp block.
package csd3_pkg;

   localparam int NumLanes = 3;

   localparam logic [1:0] REG_SMOOTH_TIME = 2'd0;
   localparam logic [1:0] REG_MAX_SPEED   = 2'd1;
   localparam logic [1:0] REG_DELTA_TIME  = 2'd2;

   localparam logic [30:0] ST_MIN = 31'd7;
   localparam logic [14:0] C_048  = 15'd31457;
   localparam logic [13:0] C_0235 = 14'd15401;
   localparam logic [16:0] Q_ONE  = 17'd65536;

   localparam logic signed [47:0] WIDE_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [49:0] WIDE_MAX_X = 50'sh0_7FFF_FFFF_FFFF;

   typedef logic signed [47:0] wide_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SQ,
      CMD_CLAMP,
      CMD_UPD,
      CMD_COMMIT
   } lane_cmd_type;

   typedef struct packed {
      lane_cmd_type cmd;
      logic         k;
      logic         snap;
      logic [30:0]  omega;
      logic [16:0]  dt;
      logic [16:0]  decay;
      logic [29:0]  r;
   } lane_ctl_type;

   typedef struct packed {
      logic               idle;
      logic               big;
      logic [61:0]        sq;
      wide_type           pos;
      wide_type           vn;
      logic signed [83:0] dot;
   } lane_sts_type;

   typedef struct packed {
      logic       start;
      logic       is_sqrt;
      logic [6:0] count;
   } ds_ctl_type;

   function automatic wide_type sat_wide(input logic signed [49:0] a);
      wide_type res;
      if (a > WIDE_MAX_X) begin
         res = WIDE_MAX;
      end else if (a < -WIDE_MAX_X) begin
         res = -WIDE_MAX;
      end else begin
         res = a[47:0];
      end
      return res;
   endfunction

   function automatic logic signed [31:0] sat_32(input wide_type a);
      logic signed [31:0] res;
      if (a > 48'sh0000_7FFF_FFFF) begin
         res = 32'sh7FFF_FFFF;
      end else if (a < -48'sh0000_8000_0000) begin
         res = 32'sh8000_0000;
      end else begin
         res = a[31:0];
      end
      return res;
   endfunction

   // magnitude of a value held to +-(2^47 - 1)
   function automatic logic [47:0] abs_wide(input wide_type a);
      wide_type n;
      n = -a;
      return a[47] ? n : a;
   endfunction

endpackage

[sv/csd3_dsu.sv]
`timescale 1ns / 1ps
// Shared bit-serial restoring divider and digit-by-digit square root.
module csd3_dsu (
   input  logic                  clock,
   input  logic                  reset,
   input  csd3_pkg::ds_ctl_type  ctl,
   input  logic [75:0]           num,
   input  logic [39:0]           divisor,
   output logic                  busy,
   output logic [33:0]           quot
);
   import csd3_pkg::*;

   logic        busy_ff;
   logic        sqrt_ff;
   logic [6:0]  cnt_ff;
   logic [75:0] num_ff;
   logic [39:0] div_ff;
   logic [40:0] rem_ff;
   logic [33:0] quo_ff;

   logic [40:0] trial_in;
   logic [40:0] cand_in;
   logic        ge_in;

   always_comb begin
      if (sqrt_ff) begin
         trial_in = {rem_ff[38:0], num_ff[75:74]};
         cand_in  = 41'({quo_ff[31:0], 2'b01});
      end else begin
         trial_in = {rem_ff[39:0], num_ff[75]};
         cand_in  = {1'b0, div_ff};
      end
      ge_in = (trial_in >= cand_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
         sqrt_ff <= ctl.is_sqrt;
         cnt_ff  <= ctl.count;
         num_ff  <= num;
         div_ff  <= divisor;
         rem_ff  <= '0;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge_in ? (trial_in - cand_in) : trial_in;
         quo_ff <= {quo_ff[32:0], ge_in};
         num_ff <= sqrt_ff ? {num_ff[73:0], 2'b00} : {num_ff[74:0], 1'b0};
         cnt_ff <= cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy = busy_ff;
   assign quot = quo_ff;

endmodule

[sv/csd3_lane.sv]
`timescale 1ns / 1ps
// One axis lane: offset, square, clamp, spring update and overshoot term on a chunked multiplier.
module csd3_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  csd3_pkg::lane_ctl_type  ctl,
   input  logic signed [31:0]      cur,
   input  logic signed [31:0]      goal,
   output csd3_pkg::lane_sts_type  sts
);
   import csd3_pkg::*;

   typedef enum logic [3:0] {
      L_IDLE, L_SQ, L_CL, L_P1, L_TMP, L_P2, L_VN, L_PO, L_DOT
   } lstate_type;

   lstate_type         state_ff;
   logic [2:0]         sub_ff;
   logic signed [33:0] c_ff;
   logic signed [31:0] vel_ff;
   wide_type           s1_ff, tmp_ff, s2_ff, s3_ff, vn_ff, pos_ff;
   logic [61:0]        sq_ff;
   logic signed [83:0] dot_ff;
   logic [47:0]        ma_ff;
   logic [33:0]        mb_ff;
   logic               neg_ff;
   logic [64:0]        pp_ff;
   logic [81:0]        acc_ff;

   logic [33:0]        abs_c;
   logic [33:0]        sq_op;
   logic signed [48:0] dg;
   logic signed [32:0] gc;
   logic [48:0]        abs_dg;
   logic [32:0]        abs_gc;
   logic [46:0]        mag;
   wide_type           mws;
   logic [47:0]        op_a_in;
   logic [33:0]        op_b_in;
   logic               op_neg_in;
   lstate_type         next_in;

   always_comb begin
      abs_c  = c_ff[33] ? 34'(-c_ff) : 34'(c_ff);
      sq_op  = ctl.k ? (abs_c >> 2) : abs_c;
      dg     = 49'(pos_ff) - 49'(goal);
      gc     = 33'(goal) - 33'(cur);
      abs_dg = dg[48] ? 49'(-dg) : 49'(dg);
      abs_gc = gc[32] ? 33'(-gc) : 33'(gc);
      // truncated magnitude, held to 2^47 - 1
      mag    = (|acc_ff[81:63]) ? 47'h7FFF_FFFF_FFFF : acc_ff[62:16];
      mws    = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_comb begin
      op_a_in   = '0;
      op_b_in   = '0;
      op_neg_in = 1'b0;
      next_in   = L_IDLE;
      case (state_ff)
         L_SQ: begin
            op_a_in = 48'(sq_op);
            op_b_in = sq_op;
         end
         L_CL: begin
            op_a_in   = 48'(abs_c);
            op_b_in   = 34'(ctl.r);
            op_neg_in = c_ff[33];
         end
         L_P1: begin
            op_a_in   = 48'(abs_c);
            op_b_in   = 34'(ctl.omega);
            op_neg_in = c_ff[33];
            next_in   = L_TMP;
         end
         L_TMP: begin
            op_a_in   = abs_wide(s1_ff);
            op_b_in   = 34'(ctl.dt);
            op_neg_in = s1_ff[47];
            next_in   = L_P2;
         end
         L_P2: begin
            op_a_in   = abs_wide(tmp_ff);
            op_b_in   = 34'(ctl.omega);
            op_neg_in = tmp_ff[47];
            next_in   = L_VN;
         end
         L_VN: begin
            op_a_in   = abs_wide(s2_ff);
            op_b_in   = 34'(ctl.decay);
            op_neg_in = s2_ff[47];
            next_in   = L_PO;
         end
         L_PO: begin
            op_a_in   = abs_wide(s3_ff);
            op_b_in   = 34'(ctl.decay);
            op_neg_in = s3_ff[47];
            next_in   = L_DOT;
         end
         L_DOT: begin
            op_a_in   = abs_dg[47:0];
            op_b_in   = 34'(abs_gc);
            op_neg_in = dg[48] ^ gc[32];
         end
         default: begin
            next_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         sub_ff   <= '0;
         vel_ff   <= '0;
      end else if (state_ff == L_IDLE) begin
         sub_ff <= '0;
         case (ctl.cmd)
            CMD_LOAD:   c_ff <= 34'(cur) - 34'(goal);
            CMD_SQ:     state_ff <= L_SQ;
            CMD_CLAMP:  state_ff <= L_CL;
            CMD_UPD:    state_ff <= L_P1;
            CMD_COMMIT: vel_ff <= ctl.snap ? '0 : sat_32(vn_ff);
            default: ;
         endcase
      end else begin
         sub_ff <= (sub_ff == 3'd4) ? 3'd0 : sub_ff + 3'd1;
         case (sub_ff)
            3'd0: begin
               ma_ff  <= op_a_in;
               mb_ff  <= op_b_in;
               neg_ff <= op_neg_in;
            end
            3'd1: pp_ff <= 65'(ma_ff) * 65'(mb_ff[16:0]);
            3'd2: begin
               acc_ff <= 82'(pp_ff);
               pp_ff  <= 65'(ma_ff) * 65'(mb_ff[33:17]);
            end
            3'd3: acc_ff <= acc_ff + (82'(pp_ff) << 17);
            default: begin
               state_ff <= next_in;
               case (state_ff)
                  L_SQ:  sq_ff <= acc_ff[61:0];
                  L_CL:  c_ff <= neg_ff ? -$signed({1'b0, acc_ff[61:29]})
                                        : $signed({1'b0, acc_ff[61:29]});
                  L_P1:  s1_ff <= sat_wide(50'(vel_ff) + 50'(mws));
                  L_TMP: tmp_ff <= mws;
                  L_P2: begin
                     s2_ff <= sat_wide(50'(vel_ff) - 50'(mws));
                     s3_ff <= sat_wide(50'(c_ff) + 50'(tmp_ff));
                  end
                  L_VN:  vn_ff <= mws;
                  L_PO:  pos_ff <= sat_wide(50'(cur) - 50'(c_ff) + 50'(mws));
                  L_DOT: dot_ff <= neg_ff ? -$signed({2'b00, acc_ff})
                                          : $signed({2'b00, acc_ff});
                  default: ;
               endcase
            end
         endcase
      end
   end

   always_comb begin
      sts.idle = (state_ff == L_IDLE);
      sts.big  = |abs_c[33:31];
      sts.sq   = sq_ff;
      sts.pos  = pos_ff;
      sts.vn   = vn_ff;
      sts.dot  = dot_ff;
   end

endmodule

[sv/critically_damped_smoothing_3d.sv]
`timescale 1ns / 1ps
// Top level: 3D critically damped smoothing, shared divide/root unit and three axis lanes.
//
//  channel   dir  handshake              payload
//  req_      in   req_tvalid/req_tready  tdata: cur_x,cur_y,cur_z,goal_x,goal_y,goal_z
//  rsp_      out  rsp_tvalid/rsp_tready  tdata: pos_x..z, vel_x..z; tuser: snapped
//  csr_      in   csr_we                 csr_index, csr_wdata
//
// One request is handled at a time. The decay divide is skipped when the decay factor is
// zero; a ratio divide and a clamp pass run when the offset gets clamped to max speed.
// The divide/root unit is bit-serial (34 + 33 + 32 steps, plus 75 for the clamp ratio),
// and the lanes multiply in two chunks.
// Reset is synchronous; it clears the stored velocity and loads the register defaults.
// A new request is taken as soon as the previous result sits in the output register.
// A stalled output holds; the next request finishes only once that slot frees up.
module critically_damped_smoothing_3d (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,   // cur_x, cur_y, cur_z, goal_x, goal_y, goal_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
   output logic         rsp_tuser,   // snapped
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [30:0]  csr_wdata
);
   import csd3_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_SQ_GO, S_OMEGA_GO, S_OMEGA_WAIT, S_XMUL, S_XSTORE, S_X2MUL,
      S_X3MUL, S_DEN1, S_DEN2, S_DECAY_GO, S_DECAY_WAIT, S_MAXC_MUL, S_MAXC_STORE,
      S_SUMSQ, S_SQRT_GO, S_SQRT_WAIT, S_CMP, S_RDIV_GO, S_RDIV_WAIT, S_CLAMP_GO,
      S_CLAMP_WAIT, S_UPD_GO, S_UPD_WAIT, S_MERGE, S_FIN
   } state_type;

   state_type          state_ff;
   logic [30:0]        smooth_time_ff, max_speed_ff, st_ff;
   logic [16:0]        delta_time_ff;
   logic [191:0]       req_ff;
   logic               k_ff;
   logic [30:0]        omega_ff;
   logic [63:0]        prod_ff;
   logic [31:0]        x_ff, x2_ff;
   logic [39:0]        x3_ff;
   logic [30:0]        t48_ff;
   logic [39:0]        den_ff;
   logic [16:0]        decay_ff;
   logic [45:0]        maxc_ff;
   logic [63:0]        sq_sum_ff;
   logic [33:0]        len_ff;
   logic [29:0]        r_ff;
   logic signed [85:0] dotsum_ff;
   logic               rsp_valid_ff;
   logic [191:0]       rsp_data_ff;
   logic               rsp_snap_ff;

   ds_ctl_type         ds_ctl;
   logic [75:0]        ds_num;
   logic [39:0]        ds_div;
   logic               ds_busy;
   logic [33:0]        ds_quot;
   lane_ctl_type       lane_ctl;
   lane_sts_type       lane_sts [NumLanes];

   logic               all_idle;
   logic               any_big;
   logic               rsp_free;
   logic               snap_in;
   logic [191:0]       rsp_data_in;
   logic [63:0]        sq_sum_in;
   logic signed [85:0] dotsum_in;

   csd3_dsu u_dsu (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ds_ctl),
      .num     (ds_num),
      .divisor (ds_div),
      .busy    (ds_busy),
      .quot    (ds_quot)
   );

   for (genvar g = 0; g < NumLanes; g++) begin : g_lane
      csd3_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (lane_ctl),
         .cur   ($signed(req_ff[32*g +: 32])),
         .goal  ($signed(req_ff[32*(g+NumLanes) +: 32])),
         .sts   (lane_sts[g])
      );
   end

   // merge stage across lanes
   always_comb begin
      all_idle  = 1'b1;
      any_big   = 1'b0;
      sq_sum_in = '0;
      dotsum_in = '0;
      for (int i = 0; i < NumLanes; i++) begin
         all_idle  = all_idle & lane_sts[i].idle;
         any_big   = any_big | lane_sts[i].big;
         sq_sum_in = sq_sum_in + 64'(lane_sts[i].sq);
         dotsum_in = dotsum_in + 86'(lane_sts[i].dot);
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign snap_in  = (dotsum_ff > 86'sd0);

   always_comb begin
      for (int i = 0; i < NumLanes; i++) begin
         rsp_data_in[32*i +: 32] = snap_in ? req_ff[32*(i+NumLanes) +: 32]
                                           : sat_32(lane_sts[i].pos);
         rsp_data_in[32*(i+NumLanes) +: 32] = snap_in ? 32'd0 : sat_32(lane_sts[i].vn);
      end
   end

   always_comb begin
      lane_ctl.cmd   = CMD_NONE;
      lane_ctl.k     = k_ff;
      lane_ctl.snap  = snap_in;
      lane_ctl.omega = omega_ff;
      lane_ctl.dt    = delta_time_ff;
      lane_ctl.decay = decay_ff;
      lane_ctl.r     = r_ff;
      case (state_ff)
         S_LOAD:     lane_ctl.cmd = CMD_LOAD;
         S_SQ_GO:    lane_ctl.cmd = CMD_SQ;
         S_CLAMP_GO: lane_ctl.cmd = CMD_CLAMP;
         S_UPD_GO:   lane_ctl.cmd = CMD_UPD;
         S_FIN:      lane_ctl.cmd = rsp_free ? CMD_COMMIT : CMD_NONE;
         default: ;
      endcase
   end

   always_comb begin
      ds_ctl = '0;
      ds_num = '0;
      ds_div = '0;
      case (state_ff)
         S_OMEGA_GO: begin
            ds_ctl = '{start: 1'b1, is_sqrt: 1'b0, count: 7'd34};
            ds_num = {34'h2_0000_0000, 42'd0};
            ds_div = 40'(st_ff);
         end
         S_DECAY_GO: begin
            ds_ctl = '{start: 1'b1, is_sqrt: 1'b0, count: 7'd33};
            ds_num = {33'h1_0000_0000, 43'd0};
            ds_div = den_ff;
         end
         S_SQRT_GO: begin
            ds_ctl = '{start: 1'b1, is_sqrt: 1'b1, count: 7'd32};
            ds_num = {sq_sum_ff, 12'd0};
         end
         S_RDIV_GO: begin
            ds_ctl = '{start: 1'b1, is_sqrt: 1'b0, count: 7'd75};
            ds_num = {maxc_ff, 30'd0};
            ds_div = 40'(len_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         smooth_time_ff <= 31'd19661;
         max_speed_ff   <= 31'h7FFF_FFFF;
         delta_time_ff  <= 17'd1092;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_SMOOTH_TIME: smooth_time_ff <= csr_wdata;
               REG_MAX_SPEED:   max_speed_ff   <= csr_wdata;
               REG_DELTA_TIME:  delta_time_ff  <= csr_wdata[16:0];
               default: ;
            endcase
         end
         if (state_ff == S_FIN && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  req_ff   <= req_tdata;
                  st_ff    <= (smooth_time_ff < ST_MIN) ? ST_MIN : smooth_time_ff;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD:  state_ff <= S_SQ_GO;
            S_SQ_GO: begin
               k_ff     <= any_big;
               state_ff <= S_OMEGA_GO;
            end
            S_OMEGA_GO: state_ff <= S_OMEGA_WAIT;
            S_OMEGA_WAIT: begin
               if (!ds_busy) begin
                  omega_ff <= ds_quot[30:0];
                  state_ff <= S_XMUL;
               end
            end
            S_XMUL: begin
               prod_ff  <= 64'(omega_ff) * 64'(delta_time_ff);
               state_ff <= S_XSTORE;
            end
            S_XSTORE: begin
               x_ff     <= prod_ff[47:16];
               state_ff <= S_X2MUL;
            end
            S_X2MUL: begin
               if (|x_ff[31:24]) begin
                  decay_ff <= '0;
                  state_ff <= S_MAXC_MUL;
               end else begin
                  prod_ff  <= 64'(x_ff[23:0]) * 64'(x_ff[23:0]);
                  state_ff <= S_X3MUL;
               end
            end
            S_X3MUL: begin
               x2_ff    <= prod_ff[47:16];
               prod_ff  <= 64'(prod_ff[47:16]) * 64'(x_ff[23:0]);
               state_ff <= S_DEN1;
            end
            S_DEN1: begin
               x3_ff    <= prod_ff[55:16];
               t48_ff   <= 31'((47'(C_048) * 47'(x2_ff)) >> 16);
               state_ff <= S_DEN2;
            end
            S_DEN2: begin
               den_ff   <= 40'(Q_ONE) + 40'(x_ff[23:0]) + 40'(t48_ff)
                         + 40'((54'(C_0235) * 54'(x3_ff)) >> 16);
               state_ff <= S_DECAY_GO;
            end
            S_DECAY_GO: state_ff <= S_DECAY_WAIT;
            S_DECAY_WAIT: begin
               if (!ds_busy) begin
                  decay_ff <= ds_quot[16:0];
                  state_ff <= S_MAXC_MUL;
               end
            end
            S_MAXC_MUL: begin
               prod_ff  <= 64'(max_speed_ff) * 64'(st_ff);
               state_ff <= S_MAXC_STORE;
            end
            S_MAXC_STORE: begin
               maxc_ff  <= prod_ff[61:16];
               state_ff <= S_SUMSQ;
            end
            S_SUMSQ: begin
               if (all_idle) begin
                  sq_sum_ff <= sq_sum_in;
                  state_ff  <= S_SQRT_GO;
               end
            end
            S_SQRT_GO: state_ff <= S_SQRT_WAIT;
            S_SQRT_WAIT: begin
               if (!ds_busy) begin
                  len_ff   <= k_ff ? {ds_quot[31:0], 2'b00} : {2'b00, ds_quot[31:0]};
                  state_ff <= S_CMP;
               end
            end
            S_CMP: state_ff <= (46'(len_ff) > maxc_ff) ? S_RDIV_GO : S_UPD_GO;
            S_RDIV_GO: state_ff <= S_RDIV_WAIT;
            S_RDIV_WAIT: begin
               if (!ds_busy) begin
                  r_ff     <= ds_quot[29:0];
                  state_ff <= S_CLAMP_GO;
               end
            end
            S_CLAMP_GO: state_ff <= S_CLAMP_WAIT;
            S_CLAMP_WAIT: begin
               if (all_idle) begin
                  state_ff <= S_UPD_GO;
               end
            end
            S_UPD_GO: state_ff <= S_UPD_WAIT;
            S_UPD_WAIT: begin
               if (all_idle) begin
                  state_ff <= S_MERGE;
               end
            end
            S_MERGE: begin
               dotsum_ff <= dotsum_in;
               state_ff  <= S_FIN;
            end
            S_FIN: begin
               if (rsp_free) begin
                  rsp_data_ff  <= rsp_data_in;
                  rsp_snap_ff  <= snap_in;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_snap_ff;

   a_snap_zero_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[191:96] == 96'd0)
      else $error("snapped result carries nonzero velocity");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !ds_busy && all_idle)
      else $error("datapath busy while controller idle");

   a_ds_start: assert property (@(posedge clock) disable iff (reset)
      $rose(ds_busy) |-> $past(ds_ctl.start))
      else $error("divide/root unit started without a request");

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN && rsp_free |=> rsp_tvalid && state_ff == S_IDLE)
      else $error("finished request not presented");

endmodule
